>>> rtl/icm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package icm_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_HALF_BIT_TICKS    = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT_TICKS = 2'd2;
  localparam logic [1:0] REG_WRITE_HOLD_TICKS  = 2'd3;

  localparam int unsigned CFG_DATA_W = 20;

  // reset values of the registers
  localparam logic [6:0]  DEVICE_ADDRESS_RST    = 7'd88;
  localparam logic [15:0] HALF_BIT_TICKS_RST    = 16'd20;
  localparam logic [7:0]  ACK_TIMEOUT_TICKS_RST = 8'd250;
  localparam logic [19:0] WRITE_HOLD_TICKS_RST  = 20'd100000;

  // input word modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // bytes clocked in by a read
  localparam logic [3:0] READ_BYTES = 4'd5;

  // one result word
  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_enable;
    logic        busy_res;
    logic        done_res;
    logic        ack_error;
    logic [31:0] read_word;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/icm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module icm_core
  import icm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  step,
  input  wire logic [1:0]            mode,
  input  wire logic [7:0]            command_high,
  input  wire logic [7:0]            command_low,
  input  wire logic                  sda_sample,
  output res_t                       res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_DONE    = 4'd1;
  localparam logic [3:0] PH_START_A = 4'd2;
  localparam logic [3:0] PH_START_B = 4'd3;
  localparam logic [3:0] PH_TX_LO   = 4'd4;
  localparam logic [3:0] PH_TX_HI   = 4'd5;
  localparam logic [3:0] PH_ACK_LO  = 4'd6;
  localparam logic [3:0] PH_ACK_HI  = 4'd7;
  localparam logic [3:0] PH_RX_LO   = 4'd8;
  localparam logic [3:0] PH_RX_HI   = 4'd9;
  localparam logic [3:0] PH_MACK_LO = 4'd10;
  localparam logic [3:0] PH_MACK_HI = 4'd11;
  localparam logic [3:0] PH_STOP_A  = 4'd12;
  localparam logic [3:0] PH_STOP_B  = 4'd13;
  localparam logic [3:0] PH_STOP_C  = 4'd14;
  localparam logic [3:0] PH_HOLD    = 4'd15;

  // configuration
  logic [6:0]  device_address;
  logic [15:0] half_bit_ticks;
  logic [7:0]  ack_timeout_ticks;
  logic [19:0] write_hold_ticks;

  // sequencer state
  logic [3:0]  phase, phase_next;
  logic [19:0] tick_timer, tick_timer_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [31:0] word_acc, word_acc_next;
  logic        is_read, is_read_next;
  logic        error_flag, error_flag_next;
  logic [15:0] held_command, held_command_next;

  logic [15:0] half_eff;
  logic [19:0] timer_inc;
  logic        phase_over;
  logic [19:0] timer_after;
  logic [2:0]  byte_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  rx_byte;
  logic        last_byte;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= DEVICE_ADDRESS_RST;
      half_bit_ticks    <= HALF_BIT_TICKS_RST;
      ack_timeout_ticks <= ACK_TIMEOUT_TICKS_RST;
      write_hold_ticks  <= WRITE_HOLD_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS:    device_address    <= cfg_data[6:0];
        REG_HALF_BIT_TICKS:    half_bit_ticks    <= cfg_data[15:0];
        REG_ACK_TIMEOUT_TICKS: ack_timeout_ticks <= cfg_data[7:0];
        REG_WRITE_HOLD_TICKS:  write_hold_ticks  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // shared phase timer: a zero half-bit time acts as one tick
  assign half_eff    = (half_bit_ticks == 16'd0) ? 16'd1 : half_bit_ticks;
  assign timer_inc   = tick_timer + 20'd1;
  assign phase_over  = (timer_inc >= {4'd0, half_eff});
  assign timer_after = phase_over ? 20'd0 : timer_inc;
  assign byte_inc    = byte_count + 3'd1;
  assign bit_inc     = bit_count + 4'd1;
  assign rx_byte     = {shift_byte[6:0], sda_sample};

  // next state for one tick
  always_comb begin
    phase_next        = phase;
    tick_timer_next   = tick_timer;
    bit_count_next    = bit_count;
    byte_count_next   = byte_count;
    shift_byte_next   = shift_byte;
    word_acc_next     = word_acc;
    is_read_next      = is_read;
    error_flag_next   = error_flag;
    held_command_next = held_command;

    unique case (phase)
      PH_IDLE, PH_DONE: begin
        phase_next = PH_IDLE;
        if (mode == MODE_WRITE || mode == MODE_READ) begin
          held_command_next = {command_high, command_low};
          is_read_next      = (mode == MODE_READ);
          error_flag_next   = 1'b0;
          bit_count_next    = 4'd0;
          byte_count_next   = 3'd0;
          if (mode == MODE_READ) begin
            word_acc_next = 32'd0;
          end
          phase_next      = PH_START_A;
          tick_timer_next = 20'd0;
        end
      end
      PH_START_A: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_START_B;
      end
      PH_START_B: begin
        tick_timer_next = timer_after;
        if (phase_over) begin
          shift_byte_next = {device_address, is_read};
          bit_count_next  = 4'd0;
          byte_count_next = 3'd0;
          phase_next      = PH_TX_LO;
        end
      end
      PH_TX_LO: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_TX_HI;
      end
      PH_TX_HI: begin
        tick_timer_next = timer_after;
        if (phase_over) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_count_next = 4'd0;
            phase_next     = PH_ACK_LO;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_TX_LO;
          end
        end
      end
      PH_ACK_LO: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        if (!sda_sample) begin
          tick_timer_next = 20'd0;
          if (is_read) begin
            byte_count_next = 3'd0;
            bit_count_next  = 4'd0;
            phase_next      = PH_RX_LO;
          end else begin
            byte_count_next = byte_inc;
            if (byte_inc >= 3'd3) begin
              phase_next = PH_STOP_A;
            end else begin
              shift_byte_next = (byte_inc == 3'd1) ? held_command[15:8]
                                                   : held_command[7:0];
              phase_next      = PH_TX_LO;
            end
          end
        end else if (timer_inc >= {12'd0, ack_timeout_ticks}) begin
          // no ack in time: abort with a stop
          error_flag_next = 1'b1;
          tick_timer_next = 20'd0;
          phase_next      = PH_STOP_A;
        end else begin
          tick_timer_next = timer_inc;
        end
      end
      PH_RX_LO: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_RX_HI;
      end
      PH_RX_HI: begin
        tick_timer_next = timer_after;
        if (phase_over) begin
          shift_byte_next = rx_byte;
          if (bit_inc >= 4'd8) begin
            bit_count_next = 4'd0;
            // third byte is the CRC and is dropped
            if (byte_count != 3'd2) begin
              word_acc_next = {word_acc[23:0], rx_byte};
            end
            phase_next = PH_MACK_LO;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_RX_LO;
          end
        end
      end
      PH_MACK_LO: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_MACK_HI;
      end
      PH_MACK_HI: begin
        tick_timer_next = timer_after;
        if (phase_over) begin
          byte_count_next = byte_inc;
          phase_next = ({1'b0, byte_inc} >= READ_BYTES) ? PH_STOP_A : PH_RX_LO;
        end
      end
      PH_STOP_A: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_STOP_B;
      end
      PH_STOP_B: begin
        tick_timer_next = timer_after;
        if (phase_over) phase_next = PH_STOP_C;
      end
      PH_STOP_C: begin
        tick_timer_next = timer_after;
        if (phase_over) begin
          if (!is_read && !error_flag && write_hold_ticks != 20'd0) begin
            phase_next = PH_HOLD;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      PH_HOLD: begin
        if (timer_inc >= write_hold_ticks) begin
          tick_timer_next = 20'd0;
          phase_next      = PH_DONE;
        end else begin
          tick_timer_next = timer_inc;
        end
      end
      default: begin
        tick_timer_next = 20'd0;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_timer   <= 20'd0;
      bit_count    <= 4'd0;
      byte_count   <= 3'd0;
      shift_byte   <= 8'd0;
      word_acc     <= 32'd0;
      is_read      <= 1'b0;
      error_flag   <= 1'b0;
      held_command <= 16'd0;
    end else if (step) begin
      phase        <= phase_next;
      tick_timer   <= tick_timer_next;
      bit_count    <= bit_count_next;
      byte_count   <= byte_count_next;
      shift_byte   <= shift_byte_next;
      word_acc     <= word_acc_next;
      is_read      <= is_read_next;
      error_flag   <= error_flag_next;
      held_command <= held_command_next;
    end
  end

  // bus drive from the phase after this tick
  assign last_byte = ({1'b0, byte_count_next} + 4'd1 >= READ_BYTES);

  always_comb begin
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.sda_enable = 1'b1;
    res.busy_res   = 1'b1;
    res.done_res   = (phase_next == PH_DONE);
    res.ack_error  = error_flag_next;
    res.read_word  = word_acc_next;
    unique case (phase_next)
      PH_IDLE, PH_DONE: res.busy_res = 1'b0;
      PH_START_B:       res.sda_level = 1'b0;
      PH_TX_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_byte_next[7];
      end
      PH_TX_HI:         res.sda_level = shift_byte_next[7];
      PH_ACK_LO, PH_RX_LO: begin
        res.scl_level  = 1'b0;
        res.sda_level  = 1'b0;
        res.sda_enable = 1'b0;
      end
      PH_ACK_HI, PH_RX_HI: begin
        res.sda_level  = 1'b0;
        res.sda_enable = 1'b0;
      end
      PH_MACK_LO: begin
        res.scl_level = 1'b0;
        res.sda_level = last_byte;
      end
      PH_MACK_HI:       res.sda_level = last_byte;
      PH_STOP_A: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
      end
      PH_STOP_B:        res.sda_level = 1'b0;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/icm_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module icm_outbuf
  import icm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  logic head_valid;
  logic skid_valid;
  res_t head;
  res_t skid;
  logic pop;

  assign pop       = head_valid & ~out_stall;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !head_valid) begin
      head_valid <= skid_valid | push;
      skid_valid <= skid_valid & push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop || !head_valid) begin
      if (skid_valid) begin
        head <= skid;
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2c_sensor_command_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_stall   mode, command_high, command_low, sda_sample
// out      out_valid / out_stall scl_level, sda_level, sda_enable, busy_res,
//                                done_res, ack_error, read_word
// cfg      cfg_write             cfg_index, cfg_data
//
// One input word (one timer tick) per clock while in_stall is low; its
// result word is registered before it is shown. The sequencer state
// updates on each accepted word. A two-word output buffer holds results
// while out_stall is high; in_stall rises only when both entries are full.
// Synchronous reset returns the bus to idle and loads the register defaults.

module i2c_sensor_command_master
  import icm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            mode,
  input  wire logic [7:0]            command_high,
  input  wire logic [7:0]            command_low,
  input  wire logic                  sda_sample,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       scl_level,
  output logic                       sda_level,
  output logic                       sda_enable,
  output logic                       busy_res,
  output logic                       done_res,
  output logic                       ack_error,
  output logic [31:0]                read_word
);

  logic step;
  res_t step_res;
  res_t out_res;

  assign step = in_valid & ~in_stall;

  icm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .mode         (mode),
    .command_high (command_high),
    .command_low  (command_low),
    .sda_sample   (sda_sample),
    .res          (step_res)
  );

  icm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign scl_level  = out_res.scl_level;
  assign sda_level  = out_res.sda_level;
  assign sda_enable = out_res.sda_enable;
  assign busy_res   = out_res.busy_res;
  assign done_res   = out_res.done_res;
  assign ack_error  = out_res.ack_error;
  assign read_word  = out_res.read_word;

endmodule

`default_nettype wire
